// File: rtl/core/brf_pkg.sv
`default_nettype none

package brf_pkg;

	// Field widths fixed by the item format.
	localparam int unsigned BYTE_W = 8;
	localparam int unsigned REQ_W  = 3;
	localparam int unsigned STAT_W = 3;
	localparam int unsigned CNT_W  = 6;

	// Line terminator characters.
	localparam logic [BYTE_W-1:0] CHR_CR = 8'h0D;
	localparam logic [BYTE_W-1:0] CHR_LF = 8'h0A;

	// Request codes as they arrive on the input channel.
	localparam logic [REQ_W-1:0] REQ_WRITE = 3'd0;
	localparam logic [REQ_W-1:0] REQ_READ  = 3'd1;
	localparam logic [REQ_W-1:0] REQ_LINE  = 3'd2;
	localparam logic [REQ_W-1:0] REQ_ALL   = 3'd3;
	localparam logic [REQ_W-1:0] REQ_CLEAR = 3'd4;

	// Status codes carried on the closing item of a request.
	localparam logic [STAT_W-1:0] STS_OK      = 3'd0;
	localparam logic [STAT_W-1:0] STS_FULL    = 3'd1;
	localparam logic [STAT_W-1:0] STS_EMPTY   = 3'd2;
	localparam logic [STAT_W-1:0] STS_NO_LINE = 3'd3;
	localparam logic [STAT_W-1:0] STS_REFUSED = 3'd4;

	// Decoded operation handed from the front end to the sequencer.
	typedef enum logic [2:0] {
		OP_WRITE,
		OP_READ,
		OP_LINE,
		OP_ALL,
		OP_CLEAR,
		OP_NOP
	} op_t;

	typedef struct packed {
		op_t               op;
		logic [BYTE_W-1:0] data;
	} cmd_t;

	// One result item.
	typedef struct packed {
		logic [BYTE_W-1:0] out_byte;
		logic              byte_valid;
		logic              last;
		logic [STAT_W-1:0] status;
		logic [CNT_W-1:0]  line_length;
		logic [CNT_W-1:0]  fill_count;
	} rsp_t;

	// Sequencer states.
	typedef enum logic [3:0] {
		ST_IDLE,
		ST_RD_EMIT,
		ST_ALL_RD,
		ST_ALL_EMIT,
		ST_SCAN_RD,
		ST_SCAN_CHK,
		ST_LINE_RD,
		ST_LINE_EMIT,
		ST_DROP_RD,
		ST_DROP_CHK,
		ST_STAT
	} state_t;

	function automatic logic is_term(input logic [BYTE_W-1:0] b);
		return (b == CHR_CR) || (b == CHR_LF);
	endfunction

endpackage

`default_nettype wire

// File: rtl/core/brf_if.sv
`default_nettype none

// Request channel.
interface brf_req_if import brf_pkg::*; ();
	logic              valid;
	logic              ready;
	logic [REQ_W-1:0]  req_type;
	logic [BYTE_W-1:0] write_byte;

	modport source (output valid, output req_type, output write_byte, input ready);
	modport sink (input valid, input req_type, input write_byte, output ready);
endinterface

// Result channel.
interface brf_rsp_if import brf_pkg::*; ();
	logic              valid;
	logic              ready;
	logic [BYTE_W-1:0] out_byte;
	logic              byte_valid;
	logic              last;
	logic [STAT_W-1:0] status;
	logic [CNT_W-1:0]  line_length;
	logic [CNT_W-1:0]  fill_count;

	modport source (output valid, output out_byte, output byte_valid, output last,
		output status, output line_length, output fill_count, input ready);
	modport sink (input valid, input out_byte, input byte_valid, input last,
		input status, input line_length, input fill_count, output ready);
endinterface

// Configuration write channel.
interface brf_cfg_if ();
	logic valid;
	logic ready;
	logic overwrite_mode;

	modport source (output valid, output overwrite_mode, input ready);
	modport sink (input valid, input overwrite_mode, output ready);
endinterface

`default_nettype wire

// File: rtl/core/brf_ram.sv
`default_nettype none

module brf_ram #(
	parameter int unsigned WIDTH = 8,
	parameter int unsigned DEPTH = 64
) (
	input  wire logic                     clk,
	input  wire logic                     we,
	input  wire logic [$clog2(DEPTH)-1:0] waddr,
	input  wire logic [WIDTH-1:0]         wdata,
	input  wire logic                     re,
	input  wire logic [$clog2(DEPTH)-1:0] raddr,
	output logic      [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem_q [DEPTH];

	// One write port, one registered read port; read data holds when idle.
	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		if (re) begin
			rdata <= mem_q[raddr];
		end
	end

endmodule

`default_nettype wire

// File: rtl/core/brf_front.sv
`default_nettype none

module brf_front import brf_pkg::*; (
	input  wire logic              clk,
	input  wire logic              arst_n,
	input  wire logic              in_valid,
	output logic                   in_ready,
	input  wire logic [REQ_W-1:0]  req_type,
	input  wire logic [BYTE_W-1:0] write_byte,
	output logic                   cmd_valid,
	output cmd_t                   cmd,
	input  wire logic              cmd_pop
);

	localparam int unsigned QDEPTH = 2;
	localparam int unsigned QPTR_W = $clog2(QDEPTH);

	cmd_t              entry_q [QDEPTH];
	logic [QPTR_W-1:0] wr_ptr_q;
	logic [QPTR_W-1:0] rd_ptr_q;
	logic [QPTR_W:0]   count_q;
	cmd_t              dec;
	logic              push;

	// Classify the incoming request.
	always_comb begin
		dec.data = write_byte;
		unique case (req_type)
			REQ_WRITE: dec.op = OP_WRITE;
			REQ_READ:  dec.op = OP_READ;
			REQ_LINE:  dec.op = OP_LINE;
			REQ_ALL:   dec.op = OP_ALL;
			REQ_CLEAR: dec.op = OP_CLEAR;
			default:   dec.op = OP_NOP;
		endcase
	end

	assign in_ready  = (count_q != (QPTR_W+1)'(QDEPTH));
	assign push      = in_valid && in_ready;
	assign cmd_valid = (count_q != '0);
	assign cmd       = entry_q[rd_ptr_q];

	// Command queue storage.
	always_ff @(posedge clk) begin
		if (push) begin
			entry_q[wr_ptr_q] <= dec;
		end
	end

	// Queue pointers and occupancy.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (push) begin
				wr_ptr_q <= wr_ptr_q + 1'b1;
			end
			if (cmd_pop) begin
				rd_ptr_q <= rd_ptr_q + 1'b1;
			end
			if (push && !cmd_pop) begin
				count_q <= count_q + 1'b1;
			end else if (!push && cmd_pop) begin
				count_q <= count_q - 1'b1;
			end
		end
	end

endmodule

`default_nettype wire

// File: rtl/core/brf_back.sv
`default_nettype none

module brf_back import brf_pkg::*; #(
	parameter int unsigned DEPTH = 64
) (
	input  wire logic clk,
	input  wire logic arst_n,
	input  wire logic overwrite_mode,
	input  wire logic cmd_valid,
	input  wire cmd_t cmd,
	output logic      cmd_pop,
	output logic      rsp_valid,
	input  wire logic rsp_ready,
	output rsp_t      rsp
);

	localparam int unsigned IDX_W = $clog2(DEPTH);

	state_t            state_q, state_d;
	logic [IDX_W-1:0]  rd_idx_q, rd_idx_d;
	logic [IDX_W-1:0]  wr_idx_q, wr_idx_d;
	logic [IDX_W-1:0]  scan_q, scan_d;
	logic [IDX_W-1:0]  cnt_q, cnt_d;
	logic [IDX_W-1:0]  len_q, len_d;
	logic [STAT_W-1:0] status_q, status_d;
	logic              out_valid_q, out_valid_d;
	rsp_t              out_q, out_d;

	logic              ram_we;
	logic [IDX_W-1:0]  ram_waddr;
	logic [BYTE_W-1:0] ram_wdata;
	logic              ram_re;
	logic [IDX_W-1:0]  ram_raddr;
	logic [BYTE_W-1:0] ram_rdata;

	logic              empty;
	logic              full;
	logic              out_free;
	logic [IDX_W:0]    diff;
	logic [IDX_W-1:0]  fill;
	rsp_t              data_item;

	function automatic logic [IDX_W-1:0] nxt(input logic [IDX_W-1:0] i);
		return (i == IDX_W'(DEPTH - 1)) ? '0 : i + 1'b1;
	endfunction

	brf_ram #(
		.WIDTH (BYTE_W),
		.DEPTH (DEPTH)
	) u_ring (
		.clk   (clk),
		.we    (ram_we),
		.waddr (ram_waddr),
		.wdata (ram_wdata),
		.re    (ram_re),
		.raddr (ram_raddr),
		.rdata (ram_rdata)
	);

	// Ring occupancy from the two indices.
	assign empty    = (rd_idx_q == wr_idx_q);
	assign full     = (nxt(wr_idx_q) == rd_idx_q);
	assign diff     = (IDX_W+1)'(wr_idx_q) - (IDX_W+1)'(rd_idx_q);
	assign fill     = (wr_idx_q >= rd_idx_q) ? IDX_W'(diff)
		: IDX_W'(diff + (IDX_W+1)'(DEPTH));
	assign out_free = !out_valid_q || rsp_ready;

	assign rsp_valid = out_valid_q;
	assign rsp       = out_q;

	// A data item carries the byte just read from the ring.
	always_comb begin
		data_item             = '0;
		data_item.out_byte    = ram_rdata;
		data_item.byte_valid  = 1'b1;
	end

	// Sequencer: next state, index updates and ring accesses.
	always_comb begin
		state_d     = state_q;
		rd_idx_d    = rd_idx_q;
		wr_idx_d    = wr_idx_q;
		scan_d      = scan_q;
		cnt_d       = cnt_q;
		len_d       = len_q;
		status_d    = status_q;
		out_valid_d = out_valid_q && !rsp_ready;
		out_d       = out_q;
		cmd_pop     = 1'b0;
		ram_we      = 1'b0;
		ram_waddr   = wr_idx_q;
		ram_wdata   = cmd.data;
		ram_re      = 1'b0;
		ram_raddr   = rd_idx_q;

		unique case (state_q)
			ST_IDLE: begin
				if (cmd_valid) begin
					cmd_pop  = 1'b1;
					len_d    = '0;
					status_d = STS_OK;
					state_d  = ST_STAT;
					unique case (cmd.op)
						OP_WRITE: begin
							if (full && !overwrite_mode) begin
								status_d = STS_FULL;
							end else begin
								// In overwrite mode a full ring loses its oldest byte.
								if (full) begin
									rd_idx_d = nxt(rd_idx_q);
								end
								ram_we   = 1'b1;
								wr_idx_d = nxt(wr_idx_q);
							end
						end
						OP_READ: begin
							if (empty) begin
								status_d = STS_EMPTY;
							end else begin
								ram_re   = 1'b1;
								rd_idx_d = nxt(rd_idx_q);
								state_d  = ST_RD_EMIT;
							end
						end
						OP_LINE: begin
							if (overwrite_mode) begin
								status_d = STS_REFUSED;
							end else if (empty) begin
								status_d = STS_EMPTY;
							end else begin
								scan_d  = rd_idx_q;
								cnt_d   = '0;
								state_d = ST_SCAN_RD;
							end
						end
						OP_ALL: begin
							if (empty) begin
								status_d = STS_EMPTY;
							end else begin
								state_d = ST_ALL_RD;
							end
						end
						OP_CLEAR: begin
							rd_idx_d = '0;
							wr_idx_d = '0;
						end
						default: begin
						end
					endcase
				end
			end
			ST_RD_EMIT: begin
				if (out_free) begin
					out_valid_d = 1'b1;
					out_d       = data_item;
					state_d     = ST_STAT;
				end
			end
			ST_ALL_RD: begin
				if (empty) begin
					state_d = ST_STAT;
				end else begin
					ram_re   = 1'b1;
					rd_idx_d = nxt(rd_idx_q);
					state_d  = ST_ALL_EMIT;
				end
			end
			ST_ALL_EMIT: begin
				if (out_free) begin
					out_valid_d = 1'b1;
					out_d       = data_item;
					len_d       = len_q + 1'b1;
					state_d     = ST_ALL_RD;
				end
			end
			ST_SCAN_RD: begin
				// Walk from the head looking for a terminator.
				if (scan_q == wr_idx_q) begin
					status_d = STS_NO_LINE;
					if (full) begin
						rd_idx_d = '0;
						wr_idx_d = '0;
					end
					state_d = ST_STAT;
				end else begin
					ram_re    = 1'b1;
					ram_raddr = scan_q;
					state_d   = ST_SCAN_CHK;
				end
			end
			ST_SCAN_CHK: begin
				if (is_term(ram_rdata)) begin
					len_d   = cnt_q;
					state_d = ST_LINE_RD;
				end else begin
					cnt_d   = cnt_q + 1'b1;
					scan_d  = nxt(scan_q);
					state_d = ST_SCAN_RD;
				end
			end
			ST_LINE_RD: begin
				// Pop the bytes in front of the terminator.
				if (cnt_q == '0) begin
					state_d = ST_DROP_RD;
				end else begin
					ram_re   = 1'b1;
					rd_idx_d = nxt(rd_idx_q);
					cnt_d    = cnt_q - 1'b1;
					state_d  = ST_LINE_EMIT;
				end
			end
			ST_LINE_EMIT: begin
				if (out_free) begin
					out_valid_d = 1'b1;
					out_d       = data_item;
					state_d     = ST_LINE_RD;
				end
			end
			ST_DROP_RD: begin
				// Discard the run of CR and LF bytes that ends the line.
				if (empty) begin
					state_d = ST_STAT;
				end else begin
					ram_re  = 1'b1;
					state_d = ST_DROP_CHK;
				end
			end
			ST_DROP_CHK: begin
				if (is_term(ram_rdata)) begin
					rd_idx_d = nxt(rd_idx_q);
					state_d  = ST_DROP_RD;
				end else begin
					state_d = ST_STAT;
				end
			end
			ST_STAT: begin
				if (out_free) begin
					out_valid_d       = 1'b1;
					out_d             = '0;
					out_d.last        = 1'b1;
					out_d.status      = status_q;
					out_d.line_length = CNT_W'(len_q);
					out_d.fill_count  = CNT_W'(fill);
					state_d           = ST_IDLE;
				end
			end
			default: begin
				state_d = ST_IDLE;
			end
		endcase
	end

	// Control state.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_IDLE;
			rd_idx_q    <= '0;
			wr_idx_q    <= '0;
			out_valid_q <= 1'b0;
		end else begin
			state_q     <= state_d;
			rd_idx_q    <= rd_idx_d;
			wr_idx_q    <= wr_idx_d;
			out_valid_q <= out_valid_d;
		end
	end

	// Working registers and the output item.
	always_ff @(posedge clk) begin
		scan_q   <= scan_d;
		cnt_q    <= cnt_d;
		len_q    <= len_d;
		status_q <= status_d;
		out_q    <= out_d;
	end

endmodule

`default_nettype wire

// File: rtl/core/byte_ring_fifo_line_split.sv
// A read all request drains the ring byte by byte. A read line request scans the bytes
// for a terminator, emits the bytes in front of it and drops the run of terminators after
// it, all through the one-read-port ring and its sequencer.
// One request is worked at a time; a two-entry queue takes up to two more meanwhile.
// Reset clears the indices, the queue, the output valid flag and overwrite mode; the ring
// itself needs no clearing pass, since only slots that were written are ever read.
`default_nettype none

module byte_ring_fifo_line_split import brf_pkg::*; #(
	parameter int unsigned DEPTH = 64
) (
	input wire logic clk,
	input wire logic arst_n,
	brf_req_if.sink  req,
	brf_rsp_if.source rsp,
	brf_cfg_if.sink  cfg
);

	logic ovw_q;
	logic cmd_valid;
	cmd_t cmd;
	logic cmd_pop;
	rsp_t rsp_item;

	// Overwrite mode register; writes are always taken.
	assign cfg.ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			ovw_q <= 1'b0;
		end else if (cfg.valid) begin
			ovw_q <= cfg.overwrite_mode;
		end
	end

	brf_front u_front (
		.clk        (clk),
		.arst_n     (arst_n),
		.in_valid   (req.valid),
		.in_ready   (req.ready),
		.req_type   (req.req_type),
		.write_byte (req.write_byte),
		.cmd_valid  (cmd_valid),
		.cmd        (cmd),
		.cmd_pop    (cmd_pop)
	);

	brf_back #(
		.DEPTH (DEPTH)
	) u_back (
		.clk            (clk),
		.arst_n         (arst_n),
		.overwrite_mode (ovw_q),
		.cmd_valid      (cmd_valid),
		.cmd            (cmd),
		.cmd_pop        (cmd_pop),
		.rsp_valid      (rsp.valid),
		.rsp_ready      (rsp.ready),
		.rsp            (rsp_item)
	);

	assign rsp.out_byte    = rsp_item.out_byte;
	assign rsp.byte_valid  = rsp_item.byte_valid;
	assign rsp.last        = rsp_item.last;
	assign rsp.status      = rsp_item.status;
	assign rsp.line_length = rsp_item.line_length;
	assign rsp.fill_count  = rsp_item.fill_count;

endmodule

`default_nettype wire

// File: rtl/core/brf_chk.sv
`default_nettype none

module brf_chk import brf_pkg::*; (
	input wire logic              clk,
	input wire logic              arst_n,
	input wire logic              rsp_valid,
	input wire logic              rsp_ready,
	input wire logic [BYTE_W-1:0] out_byte,
	input wire logic              byte_valid,
	input wire logic              last,
	input wire logic [STAT_W-1:0] status,
	input wire logic [CNT_W-1:0]  line_length
);

	// A stalled result item keeps its contents.
	a_rsp_hold: assert property (@(posedge clk) disable iff (!arst_n)
		rsp_valid && !rsp_ready |=> rsp_valid && $stable(out_byte) && $stable(last))
		else $error("result item changed while stalled");

	// Data items are never the closing item and carry no status.
	a_data_item: assert property (@(posedge clk) disable iff (!arst_n)
		rsp_valid && byte_valid |-> !last && status == STS_OK && line_length == '0)
		else $error("data item carries status fields");

	// Every item without a byte closes a request.
	a_status_item: assert property (@(posedge clk) disable iff (!arst_n)
		rsp_valid && !byte_valid |-> last && out_byte == '0)
		else $error("status item not marked last");

	// Requests that fail before moving data report no line length.
	a_fail_len: assert property (@(posedge clk) disable iff (!arst_n)
		rsp_valid && last && (status == STS_FULL || status == STS_EMPTY
			|| status == STS_REFUSED) |-> line_length == '0)
		else $error("failed request reports a line length");

endmodule

bind byte_ring_fifo_line_split brf_chk u_brf_chk (
	.clk         (clk),
	.arst_n      (arst_n),
	.rsp_valid   (rsp.valid),
	.rsp_ready   (rsp.ready),
	.out_byte    (rsp.out_byte),
	.byte_valid  (rsp.byte_valid),
	.last        (rsp.last),
	.status      (rsp.status),
	.line_length (rsp.line_length)
);

`default_nettype wire

// File: tb/byte_ring_fifo_line_split_tb.sv
`default_nettype none

module byte_ring_fifo_line_split_tb;
	import brf_pkg::*;

	localparam int unsigned DEPTH = 64;
	localparam int unsigned PTR_W = $clog2(DEPTH);
	localparam int RANDOM_ITEMS = 20;
	localparam int SETTLE_CYCLES = 8;
	localparam int DRAIN_TAIL = 16;
	localparam int LIMIT_CYCLES = 1500000;
	localparam int REPORT_CAP = 40;

	// Request codes the block treats as no-ops.
	localparam logic [REQ_W-1:0] REQ_SPARE_LO = 3'd5;
	localparam logic [REQ_W-1:0] REQ_SPARE_HI = 3'd7;

	typedef logic [PTR_W-1:0] ptr_t;

	// One row of the directed plan. A configuration row writes ow; a request
	// row sends rt/wb reps times, with wb counting up. Where typed is set, the
	// closing item is checked against sts/len/fill as written here.
	typedef struct packed {
		logic              is_cfg;
		logic              ow;
		logic [REQ_W-1:0]  rt;
		logic [BYTE_W-1:0] wb;
		logic [7:0]        reps;
		logic              typed;
		logic [STAT_W-1:0] sts;
		logic [CNT_W-1:0]  len;
		logic [CNT_W-1:0]  fill;
	} plan_row_t;

	localparam int PLAN_N = 30;

	plan_row_t step_plan [PLAN_N] = '{
		'{1'b1, 1'b0, REQ_WRITE, 8'h00, 8'd0, 1'b0, STS_OK, 6'd0, 6'd0},
		'{1'b0, 1'b0, REQ_READ, 8'h00, 8'd1, 1'b1, STS_EMPTY, 6'd0, 6'd0},
		'{1'b0, 1'b0, REQ_LINE, 8'hFF, 8'd1, 1'b1, STS_EMPTY, 6'd0, 6'd0},
		'{1'b0, 1'b0, REQ_ALL, 8'h00, 8'd1, 1'b1, STS_EMPTY, 6'd0, 6'd0},
		'{1'b0, 1'b0, REQ_SPARE_LO, 8'h00, 8'd1, 1'b1, STS_OK, 6'd0, 6'd0},
		'{1'b0, 1'b0, REQ_SPARE_HI, 8'hFF, 8'd1, 1'b1, STS_OK, 6'd0, 6'd0},
		'{1'b0, 1'b0, REQ_WRITE, 8'h00, 8'd1, 1'b1, STS_OK, 6'd0, 6'd1},
		'{1'b0, 1'b0, REQ_WRITE, 8'hFF, 8'd1, 1'b1, STS_OK, 6'd0, 6'd2},
		'{1'b0, 1'b0, REQ_WRITE, 8'h41, 8'd1, 1'b0, STS_OK, 6'd0, 6'd0},
		'{1'b0, 1'b0, REQ_WRITE, CHR_CR, 8'd1, 1'b0, STS_OK, 6'd0, 6'd0},
		'{1'b0, 1'b0, REQ_WRITE, CHR_LF, 8'd1, 1'b0, STS_OK, 6'd0, 6'd0},
		'{1'b0, 1'b0, REQ_WRITE, 8'h42, 8'd1, 1'b0, STS_OK, 6'd0, 6'd0},
		'{1'b0, 1'b0, REQ_LINE, 8'h00, 8'd1, 1'b0, STS_OK, 6'd0, 6'd0},
		'{1'b0, 1'b0, REQ_LINE, 8'h00, 8'd1, 1'b1, STS_NO_LINE, 6'd0, 6'd1},
		'{1'b0, 1'b0, REQ_READ, 8'h00, 8'd1, 1'b0, STS_OK, 6'd0, 6'd0},
		'{1'b0, 1'b0, REQ_WRITE, CHR_LF, 8'd1, 1'b0, STS_OK, 6'd0, 6'd0},
		'{1'b0, 1'b0, REQ_LINE, 8'h00, 8'd1, 1'b0, STS_OK, 6'd0, 6'd0},
		'{1'b0, 1'b0, REQ_WRITE, 8'h55, 8'd1, 1'b0, STS_OK, 6'd0, 6'd0},
		'{1'b0, 1'b0, REQ_CLEAR, 8'h00, 8'd1, 1'b1, STS_OK, 6'd0, 6'd0},
		'{1'b0, 1'b0, REQ_WRITE, 8'h20, 8'd63, 1'b0, STS_OK, 6'd0, 6'd0},
		'{1'b0, 1'b0, REQ_WRITE, 8'h99, 8'd1, 1'b1, STS_FULL, 6'd0, 6'd63},
		'{1'b0, 1'b0, REQ_LINE, 8'h00, 8'd1, 1'b1, STS_NO_LINE, 6'd0, 6'd0},
		'{1'b0, 1'b0, REQ_READ, 8'h00, 8'd1, 1'b1, STS_EMPTY, 6'd0, 6'd0},
		'{1'b0, 1'b0, REQ_WRITE, 8'h80, 8'd63, 1'b0, STS_OK, 6'd0, 6'd0},
		'{1'b1, 1'b1, REQ_WRITE, 8'h00, 8'd0, 1'b0, STS_OK, 6'd0, 6'd0},
		'{1'b0, 1'b0, REQ_WRITE, 8'hAB, 8'd1, 1'b1, STS_OK, 6'd0, 6'd63},
		'{1'b0, 1'b0, REQ_LINE, 8'h00, 8'd1, 1'b1, STS_REFUSED, 6'd0, 6'd63},
		'{1'b0, 1'b0, REQ_ALL, 8'h00, 8'd1, 1'b1, STS_OK, 6'd63, 6'd0},
		'{1'b0, 1'b0, REQ_ALL, 8'h00, 8'd1, 1'b1, STS_EMPTY, 6'd0, 6'd0},
		'{1'b1, 1'b0, REQ_WRITE, 8'h00, 8'd0, 1'b0, STS_OK, 6'd0, 6'd0}
	};

	logic clk;
	logic arst_n;

	brf_req_if req_ch ();
	brf_rsp_if rsp_ch ();
	brf_cfg_if cfg_ch ();

	byte_ring_fifo_line_split #(.DEPTH(DEPTH)) dut (
		.clk    (clk),
		.arst_n (arst_n),
		.req    (req_ch),
		.rsp    (rsp_ch),
		.cfg    (cfg_ch)
	);

	// Shadow copy of the ring and its configuration.
	logic [BYTE_W-1:0] ring_mem [DEPTH];
	ptr_t ring_head = '0;
	ptr_t ring_tail = '0;
	bit   ow_mode = 1'b0;

	rsp_t awaited_replies [$];
	int   err_count = 0;
	int   reply_no = 0;
	bit   no_idle = 1'b0;

	initial begin
		clk = 1'b0;
		forever #5 clk = ~clk;
	end

	// Run guard.
	initial begin : watchdog
		int cycles;
		cycles = 0;
		while (cycles < LIMIT_CYCLES) begin
			@(posedge clk);
			cycles++;
		end
		$display("byte_ring_fifo_line_split_tb: errors");
		$finish;
	end

	task automatic report_mismatch(input string what, input int got_v, input int want_v);
		err_count++;
		if (err_count <= REPORT_CAP)
			$display("%0t reply %0d %s: got %0h want %0h", $time, reply_no, what, got_v, want_v);
	endtask

	function automatic bit ring_empty();
		return ring_head == ring_tail;
	endfunction

	function automatic bit ring_full();
		return ptr_t'(ring_tail + 1'b1) == ring_head;
	endfunction

	function automatic logic [CNT_W-1:0] ring_fill();
		ptr_t diff;
		diff = ring_tail - ring_head;
		return CNT_W'(diff);
	endfunction

	// The pointers wrap on their own since the depth is a power of two.
	function automatic logic [BYTE_W-1:0] ring_pop();
		logic [BYTE_W-1:0] b;
		b = ring_mem[ring_head];
		ring_mem[ring_head] = '0;
		ring_head = ring_head + 1'b1;
		return b;
	endfunction

	function automatic void ring_wipe();
		foreach (ring_mem[i]) ring_mem[i] = '0;
		ring_head = '0;
		ring_tail = '0;
	endfunction

	function automatic rsp_t data_item(input logic [BYTE_W-1:0] b);
		rsp_t r;
		r = '0;
		r.out_byte = b;
		r.byte_valid = 1'b1;
		return r;
	endfunction

	// Works out one request: queues the data items and returns the closing item.
	function automatic rsp_t predict_request(input logic [REQ_W-1:0] rt,
			input logic [BYTE_W-1:0] wb);
		rsp_t closing;
		logic [STAT_W-1:0] sts;
		int n;
		ptr_t p;
		bit found;
		sts = STS_OK;
		n = 0;
		found = 1'b0;
		case (rt)
			REQ_WRITE: begin
				if (ring_full() && !ow_mode) begin
					sts = STS_FULL;
				end else begin
					if (ring_full())
						void'(ring_pop());
					ring_mem[ring_tail] = wb;
					ring_tail = ring_tail + 1'b1;
				end
			end
			REQ_READ: begin
				if (ring_empty())
					sts = STS_EMPTY;
				else
					awaited_replies.push_back(data_item(ring_pop()));
			end
			REQ_LINE: begin
				if (ow_mode) begin
					sts = STS_REFUSED;
				end else if (ring_empty()) begin
					sts = STS_EMPTY;
				end else begin
					// Look for the first terminator without consuming anything.
					p = ring_head;
					while (p != ring_tail && !found) begin
						if (ring_mem[p] == CHR_CR || ring_mem[p] == CHR_LF)
							found = 1'b1;
						else begin
							n++;
							p = p + 1'b1;
						end
					end
					if (!found) begin
						if (ring_full())
							ring_wipe();
						sts = STS_NO_LINE;
						n = 0;
					end else begin
						repeat (n) awaited_replies.push_back(data_item(ring_pop()));
						while (!ring_empty() &&
								(ring_mem[ring_head] == CHR_CR || ring_mem[ring_head] == CHR_LF))
							void'(ring_pop());
					end
				end
			end
			REQ_ALL: begin
				if (ring_empty())
					sts = STS_EMPTY;
				while (!ring_empty()) begin
					awaited_replies.push_back(data_item(ring_pop()));
					n++;
				end
			end
			REQ_CLEAR: begin
				ring_wipe();
			end
			default: begin
			end
		endcase
		closing = '0;
		closing.last = 1'b1;
		closing.status = sts;
		closing.line_length = CNT_W'(n);
		closing.fill_count = ring_fill();
		return closing;
	endfunction

	function automatic int idle_cycles();
		return no_idle ? 0 : $urandom_range(0, 14);
	endfunction

	function automatic logic [BYTE_W-1:0] random_byte();
		if ($urandom_range(0, 4) == 0)
			return $urandom_range(0, 1) ? CHR_CR : CHR_LF;
		return BYTE_W'($urandom_range(0, 255));
	endfunction

	// Sends one request and records what it should produce. Valid is left high
	// after acceptance so that back-to-back items keep it high between them.
	task automatic send_req(input logic [REQ_W-1:0] rt, input logic [BYTE_W-1:0] wb,
			input bit typed, input logic [STAT_W-1:0] t_sts,
			input logic [CNT_W-1:0] t_len, input logic [CNT_W-1:0] t_fill);
		int gap;
		rsp_t closing;
		gap = idle_cycles();
		if (gap > 0) begin
			req_ch.valid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		req_ch.valid <= 1'b1;
		req_ch.req_type <= rt;
		req_ch.write_byte <= wb;
		@(posedge clk);
		while (!req_ch.ready) @(posedge clk);
		closing = predict_request(rt, wb);
		if (typed) begin
			closing.status = t_sts;
			closing.line_length = t_len;
			closing.fill_count = t_fill;
		end
		awaited_replies.push_back(closing);
	endtask

	// Register writes happen only once every reply is in and the block has settled.
	task automatic set_overwrite(input bit mode);
		req_ch.valid <= 1'b0;
		while (awaited_replies.size() != 0) @(posedge clk);
		repeat (SETTLE_CYCLES) @(posedge clk);
		cfg_ch.valid <= 1'b1;
		cfg_ch.overwrite_mode <= mode;
		@(posedge clk);
		while (!cfg_ch.ready) @(posedge clk);
		cfg_ch.valid <= 1'b0;
		ow_mode = mode;
	endtask

	// Reply side: random stalls, then each item is checked against the oldest one due.
	initial begin : reply_sink
		rsp_t got;
		rsp_t want;
		int gap;
		rsp_ch.ready <= 1'b0;
		@(posedge clk);
		while (!arst_n) @(posedge clk);
		forever begin
			gap = idle_cycles();
			if (gap > 0) begin
				rsp_ch.ready <= 1'b0;
				repeat (gap) @(posedge clk);
			end
			rsp_ch.ready <= 1'b1;
			@(posedge clk);
			while (!rsp_ch.valid) @(posedge clk);
			reply_no++;
			got.out_byte = rsp_ch.out_byte;
			got.byte_valid = rsp_ch.byte_valid;
			got.last = rsp_ch.last;
			got.status = rsp_ch.status;
			got.line_length = rsp_ch.line_length;
			got.fill_count = rsp_ch.fill_count;
			if (awaited_replies.size() == 0) begin
				report_mismatch("unexpected item", got, 0);
			end else begin
				want = awaited_replies.pop_front();
				if (got.out_byte !== want.out_byte)
					report_mismatch("out_byte", got.out_byte, want.out_byte);
				if (got.byte_valid !== want.byte_valid)
					report_mismatch("byte_valid", got.byte_valid, want.byte_valid);
				if (got.last !== want.last)
					report_mismatch("last", got.last, want.last);
				if (got.status !== want.status)
					report_mismatch("status", got.status, want.status);
				if (got.line_length !== want.line_length)
					report_mismatch("line_length", got.line_length, want.line_length);
				if (got.fill_count !== want.fill_count)
					report_mismatch("fill_count", got.fill_count, want.fill_count);
			end
		end
	end

	// Request side: directed plan, then random phases, then drain.
	initial begin : stimulus
		plan_row_t row;
		int random_sent;
		int phase_len;
		int pick;
		logic [REQ_W-1:0] rt;
		arst_n <= 1'b0;
		req_ch.valid <= 1'b0;
		req_ch.req_type <= REQ_WRITE;
		req_ch.write_byte <= '0;
		cfg_ch.valid <= 1'b0;
		cfg_ch.overwrite_mode <= 1'b0;
		ring_wipe();
		repeat (12) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// Directed plan.
		for (int r = 0; r < PLAN_N; r++) begin
			row = step_plan[r];
			if (row.is_cfg) begin
				set_overwrite(row.ow);
			end else begin
				for (int i = 0; i < row.reps; i++)
					send_req(row.rt, row.wb + BYTE_W'(i), row.typed, row.sts, row.len, row.fill);
			end
		end

		// Random phases, each with its own mode and idling style.
		random_sent = 0;
		while (random_sent < RANDOM_ITEMS) begin
			set_overwrite($urandom_range(0, 1));
			no_idle = ($urandom_range(0, 3) == 0);
			// Now and then send a long run of writes that can fill the ring and go past full.
			if ($urandom_range(0, 5) == 0) begin
				repeat ($urandom_range(50, 66)) begin
					send_req(REQ_WRITE, random_byte(), 1'b0, STS_OK, '0, '0);
					random_sent++;
				end
			end
			phase_len = $urandom_range(8, 30);
			repeat (phase_len) begin
				pick = $urandom_range(0, 99);
				if (pick < 48)
					rt = REQ_WRITE;
				else if (pick < 60)
					rt = REQ_READ;
				else if (pick < 80)
					rt = REQ_LINE;
				else if (pick < 88)
					rt = REQ_ALL;
				else if (pick < 94)
					rt = REQ_CLEAR;
				else
					rt = REQ_W'($urandom_range(REQ_SPARE_LO, REQ_SPARE_HI));
				send_req(rt, random_byte(), 1'b0, STS_OK, '0, '0);
				random_sent++;
			end
		end
		req_ch.valid <= 1'b0;
		no_idle = 1'b0;

		// Drain and let the block go quiet.
		while (awaited_replies.size() != 0) @(posedge clk);
		repeat (DRAIN_TAIL) @(posedge clk);
		if (err_count == 0)
			$display("byte_ring_fifo_line_split_tb: clean");
		else
			$display("byte_ring_fifo_line_split_tb: errors");
		$finish;
	end

endmodule

`default_nettype wire

// File: byte_ring_fifo_line_split.f
rtl/core/brf_pkg.sv
rtl/core/brf_if.sv
rtl/core/brf_ram.sv
rtl/core/brf_front.sv
rtl/core/brf_back.sv
rtl/core/byte_ring_fifo_line_split.sv
rtl/core/brf_chk.sv
tb/byte_ring_fifo_line_split_tb.sv
